>>> rtl/i2cmts_pkg.sv
package i2cmts_pkg;

	localparam logic [7:0] ST_MASK        = 8'hF8;
	localparam logic [7:0] ST_START       = 8'h08;
	localparam logic [7:0] ST_REP_START   = 8'h10;
	localparam logic [7:0] ST_MT_SLA_ACK  = 8'h18;
	localparam logic [7:0] ST_MT_DATA_ACK = 8'h28;
	localparam logic [7:0] ST_MR_SLA_ACK  = 8'h40;
	localparam logic [7:0] ST_MR_DATA_ACK = 8'h50;
	localparam logic [7:0] ST_MR_DATA_NAK = 8'h58;

	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_EVENT = 2'd2;

	typedef enum logic [2:0] {
		ACT_NONE  = 3'd0,
		ACT_START = 3'd1,
		ACT_SEND  = 3'd2,
		ACT_RACK  = 3'd3,
		ACT_RNACK = 3'd4,
		ACT_STOP  = 3'd5
	} action_t;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_R_START = 4'd1,
		PH_R_SLAW  = 4'd2,
		PH_R_LOC   = 4'd3,
		PH_R_REP   = 4'd4,
		PH_R_SLAR  = 4'd5,
		PH_R_DACK  = 4'd6,
		PH_R_DNACK = 4'd7,
		PH_W_START = 4'd8,
		PH_W_SLAW  = 4'd9,
		PH_W_DATA  = 4'd10
	} phase_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] slave_read_addr;
		logic [7:0] slave_write_addr;
		logic [7:0] location;
		logic [7:0] length;
		logic [7:0] tx_byte;
		logic [7:0] bus_status;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] action_byte;
		logic       rx_valid;
		logic [7:0] rx_data;
		logic [7:0] rx_index;
		logic       done_res;
		logic       error;
		logic       error_sticky;
	} result_t;

endpackage

>>> rtl/i2cmts_ctrl.sv
module i2cmts_ctrl
	import i2cmts_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	output result_t res
);

	phase_t     phase_q, phase_d;
	logic [7:0] byte_count_q, byte_count_d;
	logic [7:0] total_length_q, total_length_d;
	logic       failed_q, failed_d;
	logic [7:0] saved_read_addr_q;
	logic [7:0] saved_write_addr_q;
	logic [7:0] saved_location_q;
	logic       load_saved;
	logic [7:0] expect_st;
	logic       checked;
	logic       status_ok;
	logic       ack_first;
	logic       ack_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			byte_count_q   <= '0;
			total_length_q <= '0;
			failed_q       <= 1'b0;
		end else begin
			phase_q        <= phase_d;
			byte_count_q   <= byte_count_d;
			total_length_q <= total_length_d;
			failed_q       <= failed_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load_saved) begin
			saved_read_addr_q  <= item.slave_read_addr;
			saved_write_addr_q <= item.slave_write_addr;
			saved_location_q   <= item.location;
		end
	end

	always_comb begin
		checked   = 1'b1;
		expect_st = ST_START;
		unique case (phase_q)
			PH_R_START, PH_W_START: expect_st = ST_START;
			PH_R_SLAW, PH_W_SLAW:   expect_st = ST_MT_SLA_ACK;
			PH_R_LOC:               expect_st = ST_MT_DATA_ACK;
			PH_R_REP:               expect_st = ST_REP_START;
			PH_R_SLAR:              expect_st = ST_MR_SLA_ACK;
			PH_R_DACK:              expect_st = ST_MR_DATA_ACK;
			PH_R_DNACK:             expect_st = ST_MR_DATA_NAK;
			default:                checked   = 1'b0;
		endcase
	end

	assign status_ok = !checked || ((item.bus_status & ST_MASK) == expect_st);
	assign ack_first = total_length_q > 8'd1;
	assign ack_next  = ({1'b0, byte_count_q} + 9'd2) < {1'b0, total_length_q};

	always_comb begin
		phase_d          = phase_q;
		byte_count_d     = byte_count_q;
		total_length_d   = total_length_q;
		failed_d         = failed_q;
		load_saved       = 1'b0;
		res.action       = ACT_NONE;
		res.action_byte  = '0;
		res.rx_valid     = 1'b0;
		res.rx_data      = '0;
		res.rx_index     = '0;
		res.done_res     = 1'b0;
		res.error        = 1'b0;
		if (step) begin
			case (item.cmd) inside
				CMD_READ, CMD_WRITE: begin
					if (phase_q == PH_IDLE) begin
						load_saved   = 1'b1;
						byte_count_d = '0;
						res.action   = ACT_START;
						if (item.cmd == CMD_READ) begin
							total_length_d = (item.length == 8'd0) ? 8'd1 : item.length;
							phase_d        = PH_R_START;
						end else begin
							total_length_d = item.length;
							phase_d        = PH_W_START;
						end
					end
				end
				CMD_EVENT: begin
					if (phase_q != PH_IDLE) begin
						if (!status_ok) begin
							failed_d     = 1'b1;
							phase_d      = PH_IDLE;
							res.done_res = 1'b1;
							res.error    = 1'b1;
						end else begin
							unique case (phase_q)
								PH_R_START: begin
									res.action      = ACT_SEND;
									res.action_byte = saved_write_addr_q;
									phase_d         = PH_R_SLAW;
								end
								PH_R_SLAW: begin
									res.action      = ACT_SEND;
									res.action_byte = saved_location_q;
									phase_d         = PH_R_LOC;
								end
								PH_R_LOC: begin
									res.action = ACT_START;
									phase_d    = PH_R_REP;
								end
								PH_R_REP: begin
									res.action      = ACT_SEND;
									res.action_byte = saved_read_addr_q;
									phase_d         = PH_R_SLAR;
								end
								PH_R_SLAR: begin
									byte_count_d = '0;
									res.action   = ack_first ? ACT_RACK : ACT_RNACK;
									phase_d      = ack_first ? PH_R_DACK : PH_R_DNACK;
								end
								PH_R_DACK: begin
									res.rx_valid = 1'b1;
									res.rx_data  = item.rx_byte;
									res.rx_index = byte_count_q;
									byte_count_d = byte_count_q + 8'd1;
									res.action   = ack_next ? ACT_RACK : ACT_RNACK;
									phase_d      = ack_next ? PH_R_DACK : PH_R_DNACK;
								end
								PH_R_DNACK: begin
									res.rx_valid = 1'b1;
									res.rx_data  = item.rx_byte;
									res.rx_index = total_length_q - 8'd1;
									res.action   = ACT_STOP;
									res.done_res = 1'b1;
									phase_d      = PH_IDLE;
								end
								PH_W_START: begin
									res.action      = ACT_SEND;
									res.action_byte = saved_write_addr_q;
									phase_d         = PH_W_SLAW;
								end
								PH_W_SLAW, PH_W_DATA: begin
									if (byte_count_q < total_length_q) begin
										res.action      = ACT_SEND;
										res.action_byte = item.tx_byte;
										byte_count_d    = byte_count_q + 8'd1;
										phase_d         = PH_W_DATA;
									end else begin
										res.action   = ACT_STOP;
										res.done_res = 1'b1;
										phase_d      = PH_IDLE;
									end
								end
								default: begin
									phase_d = PH_IDLE;
								end
							endcase
						end
					end
				end
				default: begin
				end
			endcase
		end
		res.error_sticky = failed_d;
	end

endmodule

>>> rtl/i2c_master_transaction_sequencer_core.sv
// Sequencer for register reads and writes on top of a byte-level I2C bus engine.
// Each input item is a command that begins a transaction or a completion event
// from the engine; each item produces exactly one result item that names the
// next engine action, any received payload byte, and the transaction status.
// An input item is taken when in_valid is high and in_stall is low; a result
// item is taken when out_valid is high and out_stall is low.
// The accepting edge loads the input register; the state machine then steps the
// item into the result register once that register is empty or being taken,
// and out_valid rises with it.
// Throughput is one item per cycle while out_stall stays low.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more item; in_stall rises only when both are full.
// Reset empties both registers, returns the state machine to idle, and clears
// the sticky error flag. Saved addresses are only meaningful after a begin.
module i2c_master_transaction_sequencer_core
	import i2cmts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [7:0] slave_read_addr,
	input  logic [7:0] slave_write_addr,
	input  logic [7:0] location,
	input  logic [7:0] length,
	input  logic [7:0] tx_byte,
	input  logic [7:0] bus_status,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] action,
	output logic [7:0] action_byte,
	output logic       rx_valid,
	output logic [7:0] rx_data,
	output logic [7:0] rx_index,
	output logic       done_res,
	output logic       error,
	output logic       error_sticky
);

	item_t   item_s1;
	logic    valid_s1;
	result_t res_d;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;
	logic    in_accept;

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= in_accept || (valid_s1 && !advance);
			out_valid_q <= advance || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.cmd              <= cmd;
			item_s1.slave_read_addr  <= slave_read_addr;
			item_s1.slave_write_addr <= slave_write_addr;
			item_s1.location         <= location;
			item_s1.length           <= length;
			item_s1.tx_byte          <= tx_byte;
			item_s1.bus_status       <= bus_status;
			item_s1.rx_byte          <= rx_byte;
		end
		if (advance) begin
			res_q <= res_d;
		end
	end

	i2cmts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.res    (res_d)
	);

	assign out_valid    = out_valid_q;
	assign action       = res_q.action;
	assign action_byte  = res_q.action_byte;
	assign rx_valid     = res_q.rx_valid;
	assign rx_data      = res_q.rx_data;
	assign rx_index     = res_q.rx_index;
	assign done_res     = res_q.done_res;
	assign error        = res_q.error;
	assign error_sticky = res_q.error_sticky;

	a_error_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> done_res && error_sticky && action == ACT_NONE)
		else $error("aborted item does not end the transaction cleanly");

	a_rx_action: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rx_valid |-> action == ACT_RACK || action == ACT_RNACK ||
			(action == ACT_STOP && done_res))
		else $error("received byte reported with an unexpected action");

	a_done_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res && !error |-> action == ACT_STOP)
		else $error("successful end without a stop action");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while the result register can drain");

endmodule

>>> tb/i2c_sequencer_action_check.sv
`timescale 1ns / 1ps

module i2c_sequencer_action_check
	import i2cmts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [7:0] slave_read_addr,
	input  logic [7:0] slave_write_addr,
	input  logic [7:0] location,
	input  logic [7:0] length,
	input  logic [7:0] tx_byte,
	input  logic [7:0] bus_status,
	input  logic [7:0] rx_byte,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [2:0] action,
	input  logic [7:0] action_byte,
	input  logic       rx_valid,
	input  logic [7:0] rx_data,
	input  logic [7:0] rx_index,
	input  logic       done_res,
	input  logic       error,
	input  logic       error_sticky,
	output int         fail_count,
	output int         pending,
	output int         results_seen,
	output int         reads_done,
	output int         writes_done,
	output int         aborts
);

	phase_t     ph;
	logic [7:0] cnt;
	logic [7:0] total;
	logic [7:0] rd_addr;
	logic [7:0] wr_addr;
	logic [7:0] loc;
	logic       sticky;

	result_t expected_actions[$];
	result_t want_r;
	result_t pred_r;
	item_t   seen_item;

	function automatic action_t receive_kind(input logic [7:0] done_cnt,
		input logic [7:0] len);
		if ({1'b0, done_cnt} + 9'd1 < {1'b0, len})
			return ACT_RACK;
		return ACT_RNACK;
	endfunction

	task automatic step_sequencer(input item_t it, output result_t r);
		logic [7:0] want;
		logic       checked;
		r = '0;
		r.action = ACT_NONE;
		want = 8'h00;
		checked = 1'b1;
		if (it.cmd == CMD_READ || it.cmd == CMD_WRITE) begin
			if (ph == PH_IDLE) begin
				wr_addr = it.slave_write_addr;
				cnt = 8'd0;
				if (it.cmd == CMD_READ) begin
					rd_addr = it.slave_read_addr;
					loc = it.location;
					total = (it.length == 8'd0) ? 8'd1 : it.length;
					ph = PH_R_START;
				end else begin
					total = it.length;
					ph = PH_W_START;
				end
				r.action = ACT_START;
			end
		end else if (it.cmd == CMD_EVENT && ph != PH_IDLE) begin
			case (ph)
				PH_R_START, PH_W_START: want = ST_START;
				PH_R_SLAW, PH_W_SLAW: want = ST_MT_SLA_ACK;
				PH_R_LOC: want = ST_MT_DATA_ACK;
				PH_R_REP: want = ST_REP_START;
				PH_R_SLAR: want = ST_MR_SLA_ACK;
				PH_R_DACK: want = ST_MR_DATA_ACK;
				PH_R_DNACK: want = ST_MR_DATA_NAK;
				default: checked = 1'b0;
			endcase
			if (checked && (it.bus_status & ST_MASK) != want) begin
				sticky = 1'b1;
				ph = PH_IDLE;
				r.done_res = 1'b1;
				r.error = 1'b1;
				aborts++;
			end else begin
				case (ph)
					PH_R_START: begin
						r.action = ACT_SEND;
						r.action_byte = wr_addr;
						ph = PH_R_SLAW;
					end
					PH_R_SLAW: begin
						r.action = ACT_SEND;
						r.action_byte = loc;
						ph = PH_R_LOC;
					end
					PH_R_LOC: begin
						r.action = ACT_START;
						ph = PH_R_REP;
					end
					PH_R_REP: begin
						r.action = ACT_SEND;
						r.action_byte = rd_addr;
						ph = PH_R_SLAR;
					end
					PH_R_SLAR: begin
						cnt = 8'd0;
						r.action = receive_kind(cnt, total);
					end
					PH_R_DACK: begin
						r.rx_valid = 1'b1;
						r.rx_data = it.rx_byte;
						r.rx_index = cnt;
						cnt = cnt + 8'd1;
						r.action = receive_kind(cnt, total);
					end
					PH_R_DNACK: begin
						r.rx_valid = 1'b1;
						r.rx_data = it.rx_byte;
						r.rx_index = total - 8'd1;
						r.action = ACT_STOP;
						r.done_res = 1'b1;
						ph = PH_IDLE;
						reads_done++;
					end
					PH_W_START: begin
						r.action = ACT_SEND;
						r.action_byte = wr_addr;
						ph = PH_W_SLAW;
					end
					default: begin
						if (cnt < total) begin
							r.action = ACT_SEND;
							r.action_byte = it.tx_byte;
							cnt = cnt + 8'd1;
							ph = PH_W_DATA;
						end else begin
							r.action = ACT_STOP;
							r.done_res = 1'b1;
							ph = PH_IDLE;
							writes_done++;
						end
					end
				endcase
				if (r.action == ACT_RACK)
					ph = PH_R_DACK;
				else if (r.action == ACT_RNACK)
					ph = PH_R_DNACK;
			end
		end
		r.error_sticky = sticky;
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph = PH_IDLE;
			cnt = 8'd0;
			total = 8'd0;
			rd_addr = 8'd0;
			wr_addr = 8'd0;
			loc = 8'd0;
			sticky = 1'b0;
			expected_actions.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_actions.size() == 0) begin
					fail_count++;
					$display("%0t: result with nothing expected, expected none, got action %0d",
						$time, action);
				end else begin
					want_r = expected_actions.pop_front();
					check_field("action", want_r.action, action);
					check_field("action_byte", want_r.action_byte, action_byte);
					check_field("rx_valid", want_r.rx_valid, rx_valid);
					check_field("rx_data", want_r.rx_data, rx_data);
					check_field("rx_index", want_r.rx_index, rx_index);
					check_field("done_res", want_r.done_res, done_res);
					check_field("error", want_r.error, error);
					check_field("error_sticky", want_r.error_sticky, error_sticky);
				end
			end
			if (in_valid && !in_stall) begin
				seen_item.cmd = cmd;
				seen_item.slave_read_addr = slave_read_addr;
				seen_item.slave_write_addr = slave_write_addr;
				seen_item.location = location;
				seen_item.length = length;
				seen_item.tx_byte = tx_byte;
				seen_item.bus_status = bus_status;
				seen_item.rx_byte = rx_byte;
				step_sequencer(seen_item, pred_r);
				expected_actions.push_back(pred_r);
			end
			pending = expected_actions.size();
		end
	end

	initial begin
		fail_count = 0;
		pending = 0;
		results_seen = 0;
		reads_done = 0;
		writes_done = 0;
		aborts = 0;
	end

endmodule

>>> tb/i2c_master_transaction_sequencer_core_tb.sv
`timescale 1ns / 1ps

module i2c_master_transaction_sequencer_core_tb;
	import i2cmts_pkg::*;

	localparam int         ITEMS = 850;
	localparam int         LIMIT = 300000;
	localparam int         HOLD_CYCLES = 200;
	localparam logic [1:0] CMD_RSVD = 2'd3;

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_stall;
	item_t stim;
	logic  out_valid;
	logic  out_stall;
	logic [2:0] action;
	logic [7:0] action_byte;
	logic       rx_valid;
	logic [7:0] rx_data;
	logic [7:0] rx_index;
	logic       done_res;
	logic       error;
	logic       error_sticky;

	int fail_count;
	int pending;
	int results_seen;
	int reads_done;
	int writes_done;
	int aborts;

	int n_items = 0;
	int cycle_cnt = 0;
	int hold_count = 0;
	bit quiet = 0;
	bit gaps_on = 1;

	i2c_master_transaction_sequencer_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(stim.cmd),
		.slave_read_addr(stim.slave_read_addr),
		.slave_write_addr(stim.slave_write_addr),
		.location(stim.location),
		.length(stim.length),
		.tx_byte(stim.tx_byte),
		.bus_status(stim.bus_status),
		.rx_byte(stim.rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.action(action),
		.action_byte(action_byte),
		.rx_valid(rx_valid),
		.rx_data(rx_data),
		.rx_index(rx_index),
		.done_res(done_res),
		.error(error),
		.error_sticky(error_sticky)
	);

	i2c_sequencer_action_check u_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(stim.cmd),
		.slave_read_addr(stim.slave_read_addr),
		.slave_write_addr(stim.slave_write_addr),
		.location(stim.location),
		.length(stim.length),
		.tx_byte(stim.tx_byte),
		.bus_status(stim.bus_status),
		.rx_byte(stim.rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.action(action),
		.action_byte(action_byte),
		.rx_valid(rx_valid),
		.rx_data(rx_data),
		.rx_index(rx_index),
		.done_res(done_res),
		.error(error),
		.error_sticky(error_sticky),
		.fail_count(fail_count),
		.pending(pending),
		.results_seen(results_seen),
		.reads_done(reads_done),
		.writes_done(writes_done),
		.aborts(aborts)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", LIMIT, pending);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic item_t random_item();
		item_t it;
		it.cmd = 2'($urandom_range(0, 3));
		it.slave_read_addr = 8'($urandom);
		it.slave_write_addr = 8'($urandom);
		it.location = 8'($urandom);
		it.length = 8'($urandom);
		it.tx_byte = 8'($urandom);
		it.bus_status = 8'($urandom);
		it.rx_byte = 8'($urandom);
		return it;
	endfunction

	function automatic logic [7:0] wrong_status(input logic [7:0] want);
		logic [7:0] s;
		s = 8'($urandom);
		if ((s & ST_MASK) == want)
			s = s ^ 8'h80;
		return s;
	endfunction

	task automatic offer(input item_t it);
		int gap;
		@(negedge clk);
		stim = it;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		n_items++;
		if (!quiet && gaps_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 15);
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic run_transfer(input item_t head, input int bad_step, input int busy_at,
		input bit rand_noise);
		item_t      it;
		logic [7:0] want;
		bit         checked;
		int         steps;
		int         k;
		offer(head);
		if (head.cmd == CMD_READ)
			steps = 5 + ((head.length == 8'd0) ? 1 : int'(head.length));
		else
			steps = 2 + int'(head.length);
		for (k = 0; k < steps; k++) begin
			if (k == busy_at || (rand_noise && $urandom_range(0, 24) == 0)) begin
				it = random_item();
				case ($urandom_range(0, 2))
					0: it.cmd = CMD_READ;
					1: it.cmd = CMD_WRITE;
					default: it.cmd = CMD_RSVD;
				endcase
				offer(it);
			end
			checked = 1'b1;
			if (head.cmd == CMD_READ) begin
				case (k)
					0: want = ST_START;
					1: want = ST_MT_SLA_ACK;
					2: want = ST_MT_DATA_ACK;
					3: want = ST_REP_START;
					4: want = ST_MR_SLA_ACK;
					default: want = (k == steps - 1) ? ST_MR_DATA_NAK : ST_MR_DATA_ACK;
				endcase
			end else begin
				want = (k == 0) ? ST_START : ST_MT_SLA_ACK;
				checked = (k < 2);
			end
			it = random_item();
			it.cmd = CMD_EVENT;
			if (checked)
				it.bus_status = {want[7:3], it.bus_status[2:0]};
			if (checked && k == bad_step) begin
				it.bus_status = wrong_status(want);
				offer(it);
				break;
			end
			offer(it);
		end
	endtask

	initial begin : receiver
		int seen;
		seen = 0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_count != seen) begin
				seen = hold_count;
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall = 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 15)) @(negedge clk);
				out_stall = 1'b0;
			end else if ($urandom_range(0, 39) == 0) begin
				repeat ($urandom_range(20, 60)) @(negedge clk);
			end
		end
	end

	initial begin : sender
		item_t head;
		item_t it;
		bit    held;
		bit    paused;
		int    bad;
		int    steps;
		held = 0;
		paused = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		stim = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		it = random_item();
		it.cmd = CMD_EVENT;
		offer(it);
		it = random_item();
		it.cmd = CMD_RSVD;
		offer(it);
		head = random_item();
		head.cmd = CMD_READ;
		head.length = 8'd0;
		head.slave_read_addr = 8'hFF;
		head.slave_write_addr = 8'h00;
		head.location = 8'hFF;
		run_transfer(head, -1, 2, 0);
		head = random_item();
		head.cmd = CMD_WRITE;
		head.length = 8'd0;
		head.slave_write_addr = 8'hFF;
		run_transfer(head, -1, -1, 0);
		head = random_item();
		head.cmd = CMD_READ;
		head.length = 8'hFF;
		run_transfer(head, 0, -1, 0);
		head = random_item();
		head.cmd = CMD_WRITE;
		head.length = 8'hFF;
		run_transfer(head, 1, -1, 0);
		head = random_item();
		head.cmd = CMD_READ;
		head.length = 8'd2;
		run_transfer(head, 5, -1, 0);

		while (n_items < ITEMS) begin
			if (n_items > ITEMS - 100)
				quiet = 1;
			if (!held && n_items > 250) begin
				held = 1;
				hold_count++;
			end
			if (!paused && n_items > 500) begin
				paused = 1;
				drain();
			end
			gaps_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 9) == 0) begin
				it = random_item();
				it.cmd = ($urandom_range(0, 1) == 0) ? CMD_EVENT : CMD_RSVD;
				offer(it);
			end else begin
				head = random_item();
				head.cmd = ($urandom_range(0, 1) == 0) ? CMD_READ : CMD_WRITE;
				case ($urandom_range(0, 19))
					0: head.length = 8'($urandom);
					1, 2, 3, 4, 5: head.length = 8'($urandom_range(0, 40));
					default: head.length = 8'($urandom_range(0, 7));
				endcase
				if (head.cmd == CMD_READ)
					steps = 5 + ((head.length == 8'd0) ? 1 : int'(head.length));
				else
					steps = 2;
				bad = ($urandom_range(0, 7) == 0) ? $urandom_range(0, steps - 1) : -1;
				run_transfer(head, bad, -1, 1);
			end
		end

		drain();
		repeat (8) @(negedge clk);
		$display("Sent %0d items and checked %0d results in %0d cycles.",
			n_items, results_seen, cycle_cnt);
		$display("Completed %0d reads and %0d writes; %0d transfers aborted on bad status.",
			reads_done, writes_done, aborts);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> i2c_master_transaction_sequencer_core.f
rtl/i2cmts_pkg.sv
rtl/i2cmts_ctrl.sv
rtl/i2c_master_transaction_sequencer_core.sv
tb/i2c_sequencer_action_check.sv
tb/i2c_master_transaction_sequencer_core_tb.sv
